/* rtl/amdfs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package amdfs_pkg;

  localparam int unsigned NODES  = 8;
  localparam int unsigned NODE_W = $clog2(NODES);
  localparam int unsigned CNT_W  = $clog2(NODES + 1);
  localparam int unsigned ADDR_W = $clog2(NODES * NODES);

  localparam int unsigned OP_W     = 2;
  localparam int unsigned VTX_W    = 4;
  localparam int unsigned COST_W   = 16;
  localparam int unsigned STATUS_W = 3;

  localparam logic [VTX_W-1:0] NODE_LIM = VTX_W'(NODES);

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_RSVD   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED   = 3'd0,
    ST_REMOVED = 3'd1,
    ST_NOTHING = 3'd2,
    ST_INVALID = 3'd3,
    ST_VISITED = 3'd4
  } status_e;

  typedef logic [ADDR_W-1:0] addr_t;

  // Control from the sequencer to the matrix store
  typedef struct packed {
    logic              we;
    addr_t             waddr;
    logic [COST_W-1:0] wdata;
    addr_t             raddr;
    logic              clr;
    addr_t             clr_a;
    addr_t             clr_b;
  } mat_req_t;

  function automatic addr_t mat_addr(input logic [NODE_W-1:0] row,
                                     input logic [NODE_W-1:0] col);
    return ADDR_W'(row) * ADDR_W'(NODES) + ADDR_W'(col);
  endfunction

endpackage

`default_nettype wire

/* rtl/amdfs_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface amdfs_req_if;
  import amdfs_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [VTX_W-1:0]    node_a;
  logic [VTX_W-1:0]    node_b;
  logic [COST_W-1:0]   cost;

  modport source (output valid, operation, node_a, node_b, cost, input ready);
  modport sink   (input valid, operation, node_a, node_b, cost, output ready);
endinterface

interface amdfs_res_if;
  import amdfs_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VTX_W-1:0]    vertex;
  logic                last;

  modport source (output valid, status, vertex, last, input ready);
  modport sink   (input valid, status, vertex, last, output ready);
endinterface

`default_nettype wire

/* rtl/amdfs_matrix.sv */
`timescale 1ns / 1ps
`default_nettype none

module amdfs_matrix (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  amdfs_pkg::mat_req_t        req_i,
  output logic                       edge_o
);
  import amdfs_pkg::*;

  localparam int unsigned DEPTH = NODES * NODES;

  logic [COST_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0]  vld_q;
  logic [COST_W-1:0] rdata_q;
  logic              rvld_q;

  // An entry never written since reset reads as no edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (req_i.clr) begin
        vld_q[req_i.clr_a] <= 1'b0;
        vld_q[req_i.clr_b] <= 1'b0;
      end
      if (req_i.we) begin
        vld_q[req_i.waddr] <= 1'b1;
      end
      rvld_q <= vld_q[req_i.raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign edge_o = rvld_q && (rdata_q != '0);

endmodule

`default_nettype wire

/* rtl/adjacency_matrix_dfs_engine_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake      Payload
// req_i    in   valid / ready  operation, node_a, node_b, cost
// res_o    out  valid / ready  status, vertex, last
//
// Edge add runs S_ADD2 then S_EMIT, edge remove S_RMCHK then S_EMIT, and a
// rejected item goes straight to S_EMIT. A search reads one matrix entry a
// cycle through the single read port of the matrix store, save while a frame
// pops or a hit waits on a busy output slot. req_i is ready only between items.
// Reset clears the matrix through per-entry valid bits, so no clearing pass.
// A result waiting in the output register stalls the walk until transferred.

module adjacency_matrix_dfs_engine_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  amdfs_req_if.sink   req_i,
  amdfs_res_if.source res_o
);
  import amdfs_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ADD2  = 5'b00010,
    S_RMCHK = 5'b00100,
    S_SCAN  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_e;

  state_e                        state_q, state_d;
  logic [NODE_W-1:0]             a_q, a_d, b_q, b_d;
  logic [COST_W-1:0]             cost_q, cost_d;
  status_e                       rst_status_q, rst_status_d;
  logic [VTX_W-1:0]              res_vertex_q, res_vertex_d;
  logic                          res_last_q, res_last_d;
  logic                          out_vld_q, out_vld_d;
  status_e                       out_status_q, out_status_d;
  logic [VTX_W-1:0]              out_vertex_q, out_vertex_d;
  logic                          out_last_q, out_last_d;
  logic [NODES-1:0]              visited_q, visited_d;
  logic [NODES-1:0][NODE_W-1:0]  stk_vtx_q, stk_vtx_d;
  logic [NODES-1:0][CNT_W-1:0]   stk_nxt_q, stk_nxt_d;
  logic [CNT_W-1:0]              depth_q, depth_d;
  logic [NODE_W-1:0]             cur_q, cur_d;
  logic [CNT_W-1:0]              scan_q, scan_d;
  logic                          chk_vld_q, chk_vld_d;
  logic [NODE_W-1:0]             chk_idx_q, chk_idx_d;
  logic [NODE_W-1:0]             pend_q, pend_d;

  mat_req_t          mreq;
  logic              mat_edge;
  logic              slot_free;
  logic              load_out;
  logic              bad_a, bad_b;
  logic              hit;
  logic [NODE_W-1:0] top_idx, pop_idx, push_idx;

  amdfs_matrix u_matrix (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .edge_o (mat_edge)
  );

  assign slot_free = !out_vld_q || res_o.ready;
  assign bad_a     = req_i.node_a >= NODE_LIM;
  assign bad_b     = req_i.node_b >= NODE_LIM;
  assign hit       = chk_vld_q && mat_edge && !visited_q[chk_idx_q];
  assign top_idx   = NODE_W'(depth_q - CNT_W'(1));
  assign pop_idx   = NODE_W'(depth_q - CNT_W'(2));
  assign push_idx  = depth_q[NODE_W-1:0];

  always_comb begin
    state_d      = state_q;
    a_d          = a_q;
    b_d          = b_q;
    cost_d       = cost_q;
    rst_status_d = rst_status_q;
    res_vertex_d = res_vertex_q;
    res_last_d   = res_last_q;
    visited_d    = visited_q;
    stk_vtx_d    = stk_vtx_q;
    stk_nxt_d    = stk_nxt_q;
    depth_d      = depth_q;
    cur_d        = cur_q;
    scan_d       = scan_q;
    chk_vld_d    = chk_vld_q;
    chk_idx_d    = chk_idx_q;
    pend_d       = pend_q;
    load_out     = 1'b0;
    out_status_d = out_status_q;
    out_vertex_d = out_vertex_q;
    out_last_d   = out_last_q;

    mreq       = '0;
    mreq.raddr = mat_addr(cur_q, scan_q[NODE_W-1:0]);

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          a_d          = req_i.node_a[NODE_W-1:0];
          b_d          = req_i.node_b[NODE_W-1:0];
          cost_d       = req_i.cost;
          res_vertex_d = '0;
          res_last_d   = 1'b1;
          case (op_e'(req_i.operation))
            OP_ADD, OP_REMOVE: begin
              if (bad_a || bad_b) begin
                rst_status_d = ST_INVALID;
                state_d      = S_EMIT;
              end else if (op_e'(req_i.operation) == OP_ADD) begin
                mreq.we    = 1'b1;
                mreq.waddr = mat_addr(req_i.node_a[NODE_W-1:0],
                                      req_i.node_b[NODE_W-1:0]);
                mreq.wdata = req_i.cost;
                state_d    = S_ADD2;
              end else begin
                mreq.raddr = mat_addr(req_i.node_a[NODE_W-1:0],
                                      req_i.node_b[NODE_W-1:0]);
                state_d    = S_RMCHK;
              end
            end
            OP_SEARCH: begin
              if (bad_b) begin
                rst_status_d = ST_INVALID;
                state_d      = S_EMIT;
              end else begin
                visited_d    = '0;
                visited_d[req_i.node_b[NODE_W-1:0]] = 1'b1;
                stk_vtx_d[0] = req_i.node_b[NODE_W-1:0];
                stk_nxt_d[0] = '0;
                depth_d      = CNT_W'(1);
                cur_d        = req_i.node_b[NODE_W-1:0];
                scan_d       = '0;
                chk_vld_d    = 1'b0;
                pend_d       = req_i.node_b[NODE_W-1:0];
                state_d      = S_SCAN;
              end
            end
            default: ; // unused code: drop the item, no result
          endcase
        end
      end

      S_ADD2: begin
        mreq.we      = 1'b1;
        mreq.waddr   = mat_addr(b_q, a_q);
        mreq.wdata   = cost_q;
        rst_status_d = ST_ADDED;
        state_d      = S_EMIT;
      end

      S_RMCHK: begin
        if (mat_edge) begin
          mreq.clr     = 1'b1;
          mreq.clr_a   = mat_addr(a_q, b_q);
          mreq.clr_b   = mat_addr(b_q, a_q);
          rst_status_d = ST_REMOVED;
        end else begin
          rst_status_d = ST_NOTHING;
        end
        state_d = S_EMIT;
      end

      S_SCAN: begin
        if (hit) begin
          // Keep reading the hit entry so it survives a busy output slot
          mreq.raddr = mat_addr(cur_q, chk_idx_q);
          // Hold the new vertex back; the previous one is known not to be last
          if (slot_free) begin
            load_out            = 1'b1;
            out_status_d        = ST_VISITED;
            out_vertex_d        = VTX_W'(pend_q);
            out_last_d          = 1'b0;
            pend_d              = chk_idx_q;
            visited_d[chk_idx_q] = 1'b1;
            stk_nxt_d[top_idx]  = CNT_W'(chk_idx_q) + CNT_W'(1);
            stk_vtx_d[push_idx] = chk_idx_q;
            stk_nxt_d[push_idx] = '0;
            depth_d             = depth_q + CNT_W'(1);
            cur_d               = chk_idx_q;
            scan_d              = '0;
            chk_vld_d           = 1'b0;
          end
        end else if (scan_q < CNT_W'(NODES)) begin
          mreq.raddr = mat_addr(cur_q, scan_q[NODE_W-1:0]);
          chk_vld_d  = 1'b1;
          chk_idx_d  = scan_q[NODE_W-1:0];
          scan_d     = scan_q + CNT_W'(1);
        end else begin
          // Row exhausted: pop the frame
          chk_vld_d = 1'b0;
          if (depth_q == CNT_W'(1)) begin
            depth_d      = '0;
            rst_status_d = ST_VISITED;
            res_vertex_d = VTX_W'(pend_q);
            res_last_d   = 1'b1;
            state_d      = S_EMIT;
          end else begin
            depth_d = depth_q - CNT_W'(1);
            cur_d   = stk_vtx_q[pop_idx];
            scan_d  = stk_nxt_q[pop_idx];
          end
        end
      end

      S_EMIT: begin
        if (slot_free) begin
          load_out     = 1'b1;
          out_status_d = rst_status_q;
          out_vertex_d = res_vertex_q;
          out_last_d   = res_last_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (load_out) begin
      out_vld_d = 1'b1;
    end else if (res_o.ready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
      visited_q <= '0;
      depth_q   <= '0;
      chk_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      visited_q <= visited_d;
      depth_q   <= depth_d;
      chk_vld_q <= chk_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q          <= a_d;
    b_q          <= b_d;
    cost_q       <= cost_d;
    rst_status_q <= rst_status_d;
    res_vertex_q <= res_vertex_d;
    res_last_q   <= res_last_d;
    out_status_q <= out_status_d;
    out_vertex_q <= out_vertex_d;
    out_last_q   <= out_last_d;
    stk_vtx_q    <= stk_vtx_d;
    stk_nxt_q    <= stk_nxt_d;
    cur_q        <= cur_d;
    scan_q       <= scan_d;
    chk_idx_q    <= chk_idx_d;
    pend_q       <= pend_d;
  end

  assign req_i.ready  = (state_q == S_IDLE);
  assign res_o.valid  = out_vld_q;
  assign res_o.status = out_status_q;
  assign res_o.vertex = out_vertex_q;
  assign res_o.last   = out_last_q;

endmodule

`default_nettype wire
